// ===== rtl/epsl_pkg.sv =====
// ----------------------------------------------------------------------------
// Encoder period speed limiter package
// Shared types, register indexes and constants.
// ----------------------------------------------------------------------------
`default_nettype none

package epsl_pkg;

    localparam int TS_W     = 16;
    localparam int DUTY_W   = 7;
    localparam int CMD_W    = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PROD_W   = 24;
    localparam int QUOT_W   = 17;

    localparam logic [DUTY_W-1:0] DUTY_MAX   = 7'd100;
    localparam logic [DUTY_W-1:0] DUTY_RESET = 7'd50;
    localparam logic [CMD_W-1:0]  CMD_MAX    = 8'd100;

    localparam logic [CFG_W-1:0]  PWM_PERIOD_RESET   = 16'd599;
    localparam logic [CFG_W-1:0]  SPEED_LIMIT_RESET  = 16'd281;
    localparam logic [CFG_W-1:0]  CAPTURE_WRAP_RESET = 16'd50000;
    localparam logic [DUTY_W-1:0] DUTY_LOW_RESET     = 7'd46;
    localparam logic [DUTY_W-1:0] DUTY_HIGH_RESET    = 7'd54;

    // ceil(2^30 / 100): exact floor division by 100 for products below 2^23
    localparam int                RECIP_SHIFT = 30;
    localparam logic [PROD_W-1:0] RECIP       = 24'd10737419;
    localparam logic [TS_W-1:0]   COMPARE_MAX = 16'hFFFF;

    localparam logic OP_CAPTURE  = 1'b0;
    localparam logic OP_SET_DUTY = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PWM_PERIOD   = 3'd0,
        CFG_SPEED_LIMIT  = 3'd1,
        CFG_CAPTURE_WRAP = 3'd2,
        CFG_DUTY_LOW     = 3'd3,
        CFG_DUTY_HIGH    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [TS_W-1:0]   interval;
        logic              interval_valid;
        logic [DUTY_W-1:0] duty;
    } t_mid;

    typedef struct packed {
        logic [TS_W-1:0]   interval;
        logic              interval_valid;
        logic [DUTY_W-1:0] duty;
        logic [TS_W-1:0]   compare;
    } t_res;

endpackage

`default_nettype wire

// ===== rtl/encoder_period_speed_limiter_top.sv =====
// ----------------------------------------------------------------------------
// Encoder period speed limiter
// Measures encoder capture intervals, nudges the duty toward the center band
// on overspeed, and reports duty and PWM compare value for every item.
// ----------------------------------------------------------------------------
// One item is accepted per cycle unless the output side stalls, and each
// gives exactly one result through the state update register, the
// period-by-duty multiply register and the divide-by-100 reciprocal multiply
// feeding the output register. Throughput is one item per clock when the
// output side is ready. Input tuser carries op (0 capture, 1 set duty); the
// first capture after reset only stores its timestamp. Configuration writes
// take effect at once and are expected only while no item is in flight.
`default_nettype none

module encoder_period_speed_limiter_top (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config write
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [epsl_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [epsl_pkg::CFG_W-1:0]          i_cfg_data,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [23:0]                         s_axis_tdata,  // timestamp, duty_value
    input  wire logic [0:0]                          s_axis_tuser,  // op
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [39:0]                              m_axis_tdata,  // interval, duty_percent,
                                                                    // compare_value, zero pad
    output logic [0:0]                               m_axis_tuser   // interval_valid
);

    logic [epsl_pkg::CFG_W-1:0]    r_pwm_period;
    logic [epsl_pkg::CFG_W-1:0]    r_speed_limit;
    logic [epsl_pkg::CFG_W-1:0]    r_capture_wrap;
    logic [epsl_pkg::DUTY_W-1:0]   r_duty_low;
    logic [epsl_pkg::DUTY_W-1:0]   r_duty_high;

    logic                          r_have_first;
    logic [epsl_pkg::TS_W-1:0]     r_prev_ts;
    logic [epsl_pkg::DUTY_W-1:0]   r_duty;

    logic                          r_s1_vld;
    epsl_pkg::t_mid                r_s1_item;

    logic                          n_have_first;
    logic [epsl_pkg::TS_W-1:0]     n_prev_ts;
    logic [epsl_pkg::DUTY_W-1:0]   n_duty;
    epsl_pkg::t_mid                n_s1_item;

    logic                          in_op;
    logic [epsl_pkg::TS_W-1:0]     in_ts;
    logic [epsl_pkg::CMD_W-1:0]    in_dv;
    logic [epsl_pkg::TS_W-1:0]     interval;
    logic                          accept;
    logic                          s1_ready;
    logic                          cmp_ready;
    epsl_pkg::t_res                res;

    assign in_op = s_axis_tuser[0];
    assign in_ts = s_axis_tdata[15:0];
    assign in_dv = s_axis_tdata[23:16];

    assign s1_ready      = !r_s1_vld || cmp_ready;
    assign s_axis_tready = s1_ready;
    assign accept        = s_axis_tvalid && s1_ready;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        if (in_ts > r_prev_ts) begin
            interval = in_ts - r_prev_ts;
        end else begin
            interval = r_capture_wrap - r_prev_ts + in_ts;
        end

        n_have_first = r_have_first;
        n_prev_ts    = r_prev_ts;
        n_duty       = r_duty;
        n_s1_item.interval       = '0;
        n_s1_item.interval_valid = 1'b0;

        if (in_op == epsl_pkg::OP_SET_DUTY) begin
            n_duty = (in_dv > epsl_pkg::CMD_MAX) ? epsl_pkg::DUTY_MAX
                                                 : in_dv[epsl_pkg::DUTY_W-1:0];
        end else if (!r_have_first) begin
            n_prev_ts    = in_ts;
            n_have_first = 1'b1;
        end else begin
            n_prev_ts                = in_ts;
            n_s1_item.interval       = interval;
            n_s1_item.interval_valid = 1'b1;
            if (interval < r_speed_limit) begin
                if (r_duty < r_duty_low) begin
                    if (r_duty < epsl_pkg::DUTY_MAX) begin
                        n_duty = r_duty + 7'd1;
                    end
                end else if (r_duty > r_duty_high) begin
                    n_duty = r_duty - 7'd1;
                end
            end
        end
        n_s1_item.duty = n_duty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period   <= epsl_pkg::PWM_PERIOD_RESET;
            r_speed_limit  <= epsl_pkg::SPEED_LIMIT_RESET;
            r_capture_wrap <= epsl_pkg::CAPTURE_WRAP_RESET;
            r_duty_low     <= epsl_pkg::DUTY_LOW_RESET;
            r_duty_high    <= epsl_pkg::DUTY_HIGH_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                epsl_pkg::CFG_PWM_PERIOD:   r_pwm_period   <= i_cfg_data;
                epsl_pkg::CFG_SPEED_LIMIT:  r_speed_limit  <= i_cfg_data;
                epsl_pkg::CFG_CAPTURE_WRAP: r_capture_wrap <= i_cfg_data;
                epsl_pkg::CFG_DUTY_LOW:     r_duty_low     <= i_cfg_data[epsl_pkg::DUTY_W-1:0];
                epsl_pkg::CFG_DUTY_HIGH:    r_duty_high    <= i_cfg_data[epsl_pkg::DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_first <= 1'b0;
            r_prev_ts    <= '0;
            r_duty       <= epsl_pkg::DUTY_RESET;
            r_s1_vld     <= 1'b0;
        end else begin
            if (accept) begin
                r_have_first <= n_have_first;
                r_prev_ts    <= n_prev_ts;
                r_duty       <= n_duty;
            end
            if (s1_ready) begin
                r_s1_vld <= s_axis_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= n_s1_item;
        end
    end

    epsl_cmp u_cmp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_s1_vld),
        .o_ready      (cmp_ready),
        .i_item       (r_s1_item),
        .i_pwm_period (r_pwm_period),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_item       (res)
    );

    assign m_axis_tdata = {1'b0, res.compare, res.duty, res.interval};
    assign m_axis_tuser = res.interval_valid;

`ifndef SYNTHESIS
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_duty <= epsl_pkg::DUTY_MAX)
        else $error("duty above limit");

    a_out_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[22:16] <= epsl_pkg::DUTY_MAX))
        else $error("result duty above limit");

    a_no_interval_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[15:0] == '0))
        else $error("interval nonzero without measurement");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !cmp_ready) |=> (r_s1_vld && $stable(r_s1_item)))
        else $error("stalled stage lost its item");
`endif

endmodule

`default_nettype wire

// ===== rtl/epsl_cmp.sv =====
// ----------------------------------------------------------------------------
// Compare value pipeline
// Scales the duty by the PWM period plus one, then divides by 100 through a
// reciprocal multiply; saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module epsl_cmp (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire epsl_pkg::t_mid                  i_item,
    input  wire logic [epsl_pkg::CFG_W-1:0]      i_pwm_period,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output epsl_pkg::t_res                       o_item
);

    logic                              r_p_vld;
    epsl_pkg::t_mid                    r_p_item;
    logic [epsl_pkg::PROD_W-1:0]       r_prod;
    logic                              r_o_vld;
    epsl_pkg::t_res                    r_o_item;

    logic                              out_ready;
    logic                              p_ready;
    logic [epsl_pkg::CFG_W:0]          period_p1;
    logic [epsl_pkg::PROD_W-1:0]       n_prod;
    logic [2*epsl_pkg::PROD_W-1:0]     scaled;
    logic [epsl_pkg::QUOT_W-1:0]       quot;
    epsl_pkg::t_res                    n_o_item;

    assign out_ready = !r_o_vld || i_ready;
    assign p_ready   = !r_p_vld || out_ready;
    assign o_ready   = p_ready;

    always_comb begin
        period_p1 = {1'b0, i_pwm_period} + {{epsl_pkg::CFG_W{1'b0}}, 1'b1};
        n_prod    = epsl_pkg::PROD_W'(period_p1) * epsl_pkg::PROD_W'(i_item.duty);
        scaled    = (2*epsl_pkg::PROD_W)'(r_prod) * (2*epsl_pkg::PROD_W)'(epsl_pkg::RECIP);
        quot      = scaled[epsl_pkg::RECIP_SHIFT+epsl_pkg::QUOT_W-1:epsl_pkg::RECIP_SHIFT];
        n_o_item.interval       = r_p_item.interval;
        n_o_item.interval_valid = r_p_item.interval_valid;
        n_o_item.duty           = r_p_item.duty;
        n_o_item.compare        = quot[epsl_pkg::QUOT_W-1] ? epsl_pkg::COMPARE_MAX
                                                           : quot[epsl_pkg::TS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (p_ready) begin
                r_p_vld <= i_valid;
            end
            if (out_ready) begin
                r_o_vld <= r_p_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (p_ready && i_valid) begin
            r_p_item <= i_item;
            r_prod   <= n_prod;
        end
        if (out_ready && r_p_vld) begin
            r_o_item <= n_o_item;
        end
    end

    assign o_valid = r_o_vld;
    assign o_item  = r_o_item;

endmodule

`default_nettype wire

// ===== tb/tb_encoder_period_speed_limiter_top.sv =====
// ----------------------------------------------------------------------------
// Encoder period speed limiter testbench
// Streams capture and set-duty items through the limiter under several
// register settings, predicts interval, duty and compare value per item, and
// checks every result in order, both sides idling at random for early items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_encoder_period_speed_limiter_top;

    import epsl_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 8;

    typedef struct packed {
        logic              op;
        logic [TS_W-1:0]   timestamp;
        logic [CMD_W-1:0]  duty_cmd;
    } t_motor_item;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [23:0]          s_axis_tdata = '0;  // timestamp, duty_value
    logic [0:0]           s_axis_tuser = '0;  // op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [39:0]          m_axis_tdata;       // interval, duty_percent, compare_value, pad
    logic [0:0]           m_axis_tuser;       // interval_valid

    encoder_period_speed_limiter_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // limiter shadow: registers and state
    logic [CFG_W-1:0]  pwm_period;
    logic [CFG_W-1:0]  speed_limit;
    logic [CFG_W-1:0]  capture_wrap;
    logic [DUTY_W-1:0] duty_low;
    logic [DUTY_W-1:0] duty_high;
    logic              have_capture;
    logic [TS_W-1:0]   last_timestamp;
    logic [DUTY_W-1:0] duty_now;

    t_motor_item pending_items[$];
    t_res        expected_results[$];
    int          items_queued = 0;
    int          items_accepted = 0;
    int          cfg_writes_seen = 0;
    int          quiet_cycles = 0;
    int          mismatches = 0;
    logic        item_taken = 1'b0;
    int          stamp_cursor = 0;

    function automatic logic [TS_W-1:0] compare_for(logic [DUTY_W-1:0] d);
        logic [31:0] prod;
        prod = ((32'(pwm_period) + 32'd1) * 32'(d)) / 32'd100;
        return (prod > 32'hFFFF) ? COMPARE_MAX : prod[TS_W-1:0];
    endfunction

    function automatic t_res limiter_step(t_motor_item it);
        t_res r;
        r = '0;
        if (it.op == OP_SET_DUTY) begin
            duty_now = (it.duty_cmd > CMD_MAX) ? DUTY_MAX : it.duty_cmd[DUTY_W-1:0];
        end else if (!have_capture) begin
            last_timestamp = it.timestamp;
            have_capture = 1'b1;
        end else begin
            if (it.timestamp > last_timestamp)
                r.interval = it.timestamp - last_timestamp;
            else
                r.interval = capture_wrap - last_timestamp + it.timestamp;
            r.interval_valid = 1'b1;
            last_timestamp = it.timestamp;
            if (r.interval < speed_limit) begin
                if (duty_now < duty_low) begin
                    if (duty_now < DUTY_MAX)
                        duty_now = duty_now + 7'd1;
                end else if (duty_now > duty_high) begin
                    duty_now = duty_now - 7'd1;
                end
            end
        end
        r.duty = duty_now;
        r.compare = compare_for(duty_now);
        return r;
    endfunction

    function automatic int send_idle_pct();
        if (items_accepted < 620) return 21;
        if (items_accepted < 1240) return 75;
        return 0;
    endfunction

    function automatic int recv_idle_pct();
        if (items_accepted < 620) return 75;
        if (items_accepted < 1240) return 21;
        return 0;
    endfunction

    // driver
    always @(negedge i_clk) begin
        t_motor_item nxt_item;
        if (i_rst_n && (!s_axis_tvalid || item_taken)) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct()) begin
                nxt_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {nxt_item.duty_cmd, nxt_item.timestamp};
                s_axis_tuser  <= nxt_item.op;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= i_rst_n && ($urandom_range(99) >= recv_idle_pct());
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        t_res        got;
        t_res        want;
        t_motor_item acc;
        logic        any_hs;
        any_hs = 1'b0;
        if (!i_rst_n) begin
            pwm_period     = PWM_PERIOD_RESET;
            speed_limit    = SPEED_LIMIT_RESET;
            capture_wrap   = CAPTURE_WRAP_RESET;
            duty_low       = DUTY_LOW_RESET;
            duty_high      = DUTY_HIGH_RESET;
            have_capture   = 1'b0;
            last_timestamp = '0;
            duty_now       = DUTY_RESET;
            item_taken    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                any_hs = 1'b1;
                case (t_cfg_idx'(i_cfg_index))
                    CFG_PWM_PERIOD:   pwm_period = i_cfg_data;
                    CFG_SPEED_LIMIT:  speed_limit = i_cfg_data;
                    CFG_CAPTURE_WRAP: capture_wrap = i_cfg_data;
                    CFG_DUTY_LOW:     duty_low = i_cfg_data[DUTY_W-1:0];
                    CFG_DUTY_HIGH:    duty_high = i_cfg_data[DUTY_W-1:0];
                    default: ;
                endcase
                cfg_writes_seen++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                any_hs = 1'b1;
                got.interval       = m_axis_tdata[15:0];
                got.duty           = m_axis_tdata[22:16];
                got.compare        = m_axis_tdata[38:23];
                got.interval_valid = m_axis_tuser[0];
                if (expected_results.size() == 0) begin
                    $display("%0t unexpected result: got %h", $time, got);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.interval !== want.interval) begin
                        $display("%0t interval: expected %0d, actual %0d",
                                 $time, want.interval, got.interval);
                        mismatches++;
                    end
                    if (got.interval_valid !== want.interval_valid) begin
                        $display("%0t interval_valid: expected %0d, actual %0d",
                                 $time, want.interval_valid, got.interval_valid);
                        mismatches++;
                    end
                    if (got.duty !== want.duty) begin
                        $display("%0t duty_percent: expected %0d, actual %0d",
                                 $time, want.duty, got.duty);
                        mismatches++;
                    end
                    if (got.compare !== want.compare) begin
                        $display("%0t compare_value: expected %0d, actual %0d",
                                 $time, want.compare, got.compare);
                        mismatches++;
                    end
                end
            end
            item_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                any_hs = 1'b1;
                acc.op        = s_axis_tuser[0];
                acc.timestamp = s_axis_tdata[15:0];
                acc.duty_cmd  = s_axis_tdata[23:16];
                expected_results.push_back(limiter_step(acc));
                items_accepted++;
            end
        end
        quiet_cycles = any_hs ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic push_item(logic op, logic [TS_W-1:0] ts, logic [CMD_W-1:0] dv);
        t_motor_item it;
        it.op = op;
        it.timestamp = ts;
        it.duty_cmd = dv;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic drain();
        while (items_accepted != items_queued || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_W-1:0] val);
        int seen;
        seen = cfg_writes_seen;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(negedge i_clk); while (cfg_writes_seen == seen);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_limiter(logic [15:0] pwm, logic [15:0] spd, logic [15:0] wrap,
                                   logic [6:0] lo, logic [6:0] hi);
        cfg_write(CFG_PWM_PERIOD, pwm);
        cfg_write(CFG_SPEED_LIMIT, spd);
        cfg_write(CFG_CAPTURE_WRAP, wrap);
        cfg_write(CFG_DUTY_LOW, {9'd0, lo});
        cfg_write(CFG_DUTY_HIGH, {9'd0, hi});
    endtask

    // mostly capture trains paced around the speed limit, with duty commands and noise
    task automatic push_random(int n);
        int roll;
        int span;
        int delta;
        int wrap;
        for (int i = 0; i < n; i++) begin
            roll = $urandom_range(99);
            if (roll < 18) begin
                push_item(OP_SET_DUTY, 16'($urandom),
                          (roll < 6) ? 8'($urandom_range(255)) : 8'($urandom_range(100)));
            end else if (roll < 26) begin
                push_item(OP_CAPTURE, 16'($urandom), 8'($urandom));
            end else begin
                span = int'(speed_limit) + int'(speed_limit) / 2 + 1;
                delta = ($urandom_range(99) < 65) ? $urandom_range(span) : $urandom_range(65535);
                wrap = int'(capture_wrap);
                stamp_cursor = stamp_cursor + delta;
                stamp_cursor = (wrap != 0) ? stamp_cursor % wrap : stamp_cursor % 65536;
                push_item(OP_CAPTURE, 16'(stamp_cursor), 8'($urandom));
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_item(OP_CAPTURE, 16'd0, 8'hFF);
        push_item(OP_CAPTURE, 16'hFFFF, 8'h00);
        push_item(OP_CAPTURE, 16'hFFFF, 8'h00);
        push_item(OP_CAPTURE, 16'd0, 8'h00);
        push_item(OP_SET_DUTY, 16'hFFFF, 8'd0);
        push_item(OP_SET_DUTY, 16'd0, 8'd255);
        push_item(OP_SET_DUTY, 16'd0, 8'd101);
        push_item(OP_SET_DUTY, 16'd0, 8'd100);
        push_item(OP_SET_DUTY, 16'd0, 8'd44);
        push_item(OP_CAPTURE, 16'd100, 8'd0);
        push_item(OP_CAPTURE, 16'd200, 8'd0);
        push_item(OP_CAPTURE, 16'd300, 8'd0);
        push_item(OP_CAPTURE, 16'd301, 8'd0);
        push_item(OP_SET_DUTY, 16'd0, 8'd60);
        push_item(OP_CAPTURE, 16'd350, 8'd0);
        push_item(OP_CAPTURE, 16'd360, 8'd0);
        push_item(OP_CAPTURE, 16'd641, 8'd0);
        push_item(OP_SET_DUTY, 16'd0, 8'd54);
        push_item(OP_CAPTURE, 16'd650, 8'd0);
        push_item(OP_CAPTURE, 16'd49999, 8'd0);
        push_item(OP_CAPTURE, 16'd10, 8'd0);
        push_item(OP_CAPTURE, 16'd10, 8'd0);
        push_random(290);
        drain();

        program_limiter(16'd0, 16'hFFFF, 16'hFFFF, 7'd100, 7'd100);
        push_random(300);
        drain();

        program_limiter(16'd65534, 16'd0, 16'd1, 7'd0, 7'd0);
        push_random(300);
        drain();

        program_limiter(16'hFFFF, 16'd40000, 16'd0, 7'd127, 7'd127);
        push_item(OP_SET_DUTY, 16'd0, 8'd100);
        push_random(300);
        drain();

        program_limiter(16'd999, 16'd300, 16'd50000, 7'd30, 7'd70);
        push_random(300);
        drain();

        program_limiter(16'($urandom_range(65534)), 16'($urandom_range(2000)),
                        16'($urandom_range(65535, 1)), 7'($urandom_range(100)),
                        7'($urandom_range(100)));
        push_random(340);
        drain();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/epsl_pkg.sv
rtl/epsl_cmp.sv
rtl/encoder_period_speed_limiter_top.sv
tb/tb_encoder_period_speed_limiter_top.sv
